@@ hw/rtl/kmsa_pkg.sv @@
// Shared types and constants for the k-way merge / key aggregation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package kmsa_pkg;

   // Defaults for the top-level parameters
   localparam int NUM_STREAMS_DEF = 8;
   localparam int KEY_OCTETS_DEF  = 8;

   // Fixed field widths of the stream items
   localparam int STREAM_W = 3;
   localparam int KEY_FULL_W = 64;
   localparam int COUNT_W = 32;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_STREAMS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LENGTH     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_COUNT      = 2'd2;

   // Register reset values
   localparam logic [3:0]         ACTIVE_STREAMS_RST = 4'd8;
   localparam logic [3:0]         KEY_LENGTH_RST     = 4'd8;
   localparam logic [COUNT_W-1:0] MIN_COUNT_RST      = 32'd1;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_ENTRY  = 2'd0,
      KIND_REFILL = 2'd1,
      KIND_DONE   = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   // One result item
   typedef struct packed {
      kind_type              kind;
      logic [KEY_FULL_W-1:0] merged_key;
      logic [COUNT_W-1:0]    total_count;
      logic [STREAM_W-1:0]   wanted_stream;
      logic                  last_in_run;
   } rsp_type;

   // Controls from the sequencer to the minimum search unit
   typedef struct packed {
      logic clear;
      logic compare;
   } min_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/kway_merge_sum_aggregate_top.sv @@
// K-way merge of key-sorted (key,count) streams with summing of equal keys.
// Depends on kmsa_pkg, kmsa_head_mem and kmsa_min_unit.
//
// Usage: every stream first sends one head entry (or an end mark, req_tlast)
// on the req_ channel, req_tuser naming the stream. Once every active stream
// holds a head or has ended, the block pops the smallest head and answers on
// the rsp_ channel: optionally a finished merged entry, then a refill request
// naming the stream that must send its next item. When all streams have ended
// it flushes the last sum, sends done and rearms for a new merge. Unexpected
// items get one reject result. The final result caused by an item has
// rsp_tlast set. Registers are written on the csr_ port between items.
// Sequence: an item that only fills a head passes S_APPLY and S_FILLCHK
// before the next item is taken; a rejected item passes S_APPLY and S_EMIT_B.
// An item that triggers a pop also runs S_SEARCH, the sweep of the single
// shared comparator over the clamped active stream heads, one head per cycle,
// read from the head memory port, then S_POP, S_EMIT_A when a finished entry
// goes out ahead of the refill request, and S_EMIT_B. One result register
// parts the channels, so the next item is taken while a result still waits;
// a stalled rsp_ side holds the block only when it has another result to
// hand over. Synchronous reset clears all control state and loads the
// register defaults; the head memory needs no clearing pass.
`default_nettype none

module kway_merge_sum_aggregate_top
   import kmsa_pkg::*;
#(
   parameter int NUM_STREAMS = NUM_STREAMS_DEF,
   parameter int KEY_OCTETS  = KEY_OCTETS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input items
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [95:0]           req_tdata,   // key[63:0], count[95:64]
   input  wire logic [STREAM_W-1:0]   req_tuser,   // stream[2:0]
   input  wire logic                  req_tlast,   // end_of_stream
   // Results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [103:0]          rsp_tdata,   // merged_key[63:0], total_count[95:64],
                                                   // wanted_stream[98:96], zero pad[103:99]
   output logic      [1:0]            rsp_tuser,   // kind[1:0]
   output logic                       rsp_tlast,   // last_in_run
   // Configuration writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W     = $clog2(NUM_STREAMS);
   localparam int CNT_W     = $clog2(NUM_STREAMS + 1);
   localparam int KEY_W     = 8 * KEY_OCTETS;
   localparam int KEY_SHIFT = KEY_FULL_W - KEY_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_FILLCHK,
      S_SEARCH,
      S_POP,
      S_EMIT_A,
      S_EMIT_B
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [3:0]         act_cfg_ff, act_cfg_in;
   logic [3:0]         klen_cfg_ff, klen_cfg_in;
   logic [COUNT_W-1:0] min_cnt_ff, min_cnt_in;

   // Captured input item
   logic [STREAM_W-1:0] item_stream_ff, item_stream_in;
   logic [KEY_W-1:0]    item_key_ff, item_key_in;
   logic [COUNT_W-1:0]  item_count_ff, item_count_in;
   logic                item_eos_ff, item_eos_in;

   // Merge state
   logic [NUM_STREAMS-1:0] head_valid_ff, head_valid_in;
   logic [NUM_STREAMS-1:0] ended_ff, ended_in;
   logic                   filling_ff, filling_in;
   logic [IDX_W-1:0]       awaited_ff, awaited_in;
   logic                   run_open_ff, run_open_in;
   logic [KEY_W-1:0]       run_key_ff, run_key_in;
   logic [COUNT_W-1:0]     run_sum_ff, run_sum_in;

   // Search sweep
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             look_vld_ff, look_vld_in;
   logic [IDX_W-1:0] look_idx_ff, look_idx_in;

   // Pending results and output register
   logic    has_a_ff, has_a_in;
   rsp_type pend_a_ff, pend_a_in;
   rsp_type pend_b_ff, pend_b_in;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   // Derived values
   logic [CNT_W-1:0]       act_eff;
   logic [3:0]             kb_eff;
   logic [KEY_W-1:0]       key_mask;
   logic [NUM_STREAMS-1:0] act_bits;
   logic                   all_ready;
   logic [IDX_W-1:0]       item_idx;
   logic                   item_ok;
   logic                   out_free;
   logic                   emit_old;
   logic [COUNT_W:0]       sum_wide;
   rsp_type                old_entry;

   // Memory and search unit wiring
   logic               mem_we;
   logic [KEY_W-1:0]   rd_key;
   logic [COUNT_W-1:0] rd_count;
   min_ctl_type        min_ctl;
   logic               cmp_live;
   logic               best_found;
   logic [IDX_W-1:0]   best_idx;
   logic [KEY_W-1:0]   best_key;
   logic [COUNT_W-1:0] best_count;

   // Clamp the registers to their usable ranges
   always_comb begin
      if (act_cfg_ff == 4'd0) begin
         act_eff = CNT_W'(1);
      end else if (32'(act_cfg_ff) > NUM_STREAMS) begin
         act_eff = CNT_W'(NUM_STREAMS);
      end else begin
         act_eff = CNT_W'(act_cfg_ff);
      end
      if (klen_cfg_ff == 4'd0) begin
         kb_eff = 4'd1;
      end else if (32'(klen_cfg_ff) > KEY_OCTETS) begin
         kb_eff = 4'(KEY_OCTETS);
      end else begin
         kb_eff = klen_cfg_ff;
      end
   end

   // Keep the leading kb_eff bytes of the stored key
   assign key_mask = ~({KEY_W{1'b1}} >> {kb_eff, 3'b000});

   always_comb begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
         act_bits[i] = (32'(i) < 32'(act_eff));
      end
   end

   assign all_ready = &(head_valid_ff | ended_ff | ~act_bits);

   // Accept check for the captured item
   assign item_idx = IDX_W'(item_stream_ff);
   assign item_ok  = (32'(item_stream_ff) < 32'(act_eff))
                     && !head_valid_ff[item_idx] && !ended_ff[item_idx]
                     && (filling_ff || (item_idx == awaited_ff));

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Finished run, ready to be flushed
   assign emit_old = run_open_ff && (run_sum_ff >= min_cnt_ff);
   assign sum_wide = {1'b0, run_sum_ff} + {1'b0, best_count};

   always_comb begin
      old_entry               = '0;
      old_entry.kind          = KIND_ENTRY;
      old_entry.merged_key    = KEY_FULL_W'(run_key_ff) << KEY_SHIFT;
      old_entry.total_count   = run_sum_ff;
   end

   // Head store and search unit
   assign mem_we = (state_ff == S_APPLY) && item_ok && !item_eos_ff;

   kmsa_head_mem #(
      .NUM_STREAMS (NUM_STREAMS),
      .KEY_W       (KEY_W)
   ) u_head_mem (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (item_idx),
      .wr_key   (item_key_ff),
      .wr_count (item_count_ff),
      .rd_addr  (cnt_ff[IDX_W-1:0]),
      .rd_key   (rd_key),
      .rd_count (rd_count)
   );

   assign min_ctl.clear   = (state_ff == S_FILLCHK);
   assign min_ctl.compare = (state_ff == S_SEARCH) && look_vld_ff;
   assign cmp_live        = head_valid_ff[look_idx_ff];

   kmsa_min_unit #(
      .NUM_STREAMS (NUM_STREAMS),
      .KEY_W       (KEY_W)
   ) u_min_unit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (min_ctl),
      .cmp_live   (cmp_live),
      .cmp_idx    (look_idx_ff),
      .cmp_key    (rd_key & key_mask),
      .cmp_count  (rd_count),
      .best_found (best_found),
      .best_idx   (best_idx),
      .best_key   (best_key),
      .best_count (best_count)
   );

   // Sequencer: next-state and next-register logic
   always_comb begin
      state_in       = state_ff;
      act_cfg_in     = act_cfg_ff;
      klen_cfg_in    = klen_cfg_ff;
      min_cnt_in     = min_cnt_ff;
      item_stream_in = item_stream_ff;
      item_key_in    = item_key_ff;
      item_count_in  = item_count_ff;
      item_eos_in    = item_eos_ff;
      head_valid_in  = head_valid_ff;
      ended_in       = ended_ff;
      filling_in     = filling_ff;
      awaited_in     = awaited_ff;
      run_open_in    = run_open_ff;
      run_key_in     = run_key_ff;
      run_sum_in     = run_sum_ff;
      cnt_in         = cnt_ff;
      look_vld_in    = 1'b0;
      look_idx_in    = look_idx_ff;
      has_a_in       = has_a_ff;
      pend_a_in      = pend_a_ff;
      pend_b_in      = pend_b_ff;
      rsp_vld_in     = rsp_vld_ff;
      rsp_in         = rsp_ff;

      // Configuration writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_ACTIVE_STREAMS: act_cfg_in  = csr_wdata[3:0];
            CSR_KEY_LENGTH:     klen_cfg_in = csr_wdata[3:0];
            CSR_MIN_COUNT:      min_cnt_in  = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      // Drop the result once the receiver takes it
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_stream_in = req_tuser;
               item_key_in    = req_tdata[KEY_FULL_W-1 -: KEY_W];
               item_count_in  = req_tdata[KEY_FULL_W +: COUNT_W];
               item_eos_in    = req_tlast;
               state_in       = S_APPLY;
            end
         end
         S_APPLY: begin
            if (!item_ok) begin
               pend_b_in             = '0;
               pend_b_in.kind        = KIND_REJECT;
               pend_b_in.last_in_run = 1'b1;
               state_in              = S_EMIT_B;
            end else begin
               if (item_eos_ff) begin
                  ended_in[item_idx] = 1'b1;
               end else begin
                  head_valid_in[item_idx] = 1'b1;
               end
               state_in = S_FILLCHK;
            end
         end
         S_FILLCHK: begin
            if (filling_ff && !all_ready) begin
               state_in = S_IDLE;
            end else begin
               filling_in = 1'b0;
               cnt_in     = '0;
               state_in   = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // Issue one head read per cycle; each compare runs in the cycle after its read
            if (cnt_ff < act_eff) begin
               look_vld_in = 1'b1;
               look_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            pend_a_in = old_entry;
            pend_b_in = '0;
            pend_b_in.last_in_run = 1'b1;
            if (!best_found) begin
               // All streams ended: flush, signal done and rearm
               has_a_in       = emit_old;
               pend_b_in.kind = KIND_DONE;
               head_valid_in  = '0;
               ended_in       = '0;
               run_open_in    = 1'b0;
               run_key_in     = '0;
               run_sum_in     = '0;
               awaited_in     = '0;
               filling_in     = 1'b1;
            end else begin
               head_valid_in[best_idx] = 1'b0;
               if (run_open_ff && (run_key_ff == best_key)) begin
                  has_a_in   = 1'b0;
                  run_sum_in = sum_wide[COUNT_W] ? {COUNT_W{1'b1}} : sum_wide[COUNT_W-1:0];
               end else begin
                  has_a_in    = emit_old;
                  run_key_in  = best_key;
                  run_sum_in  = best_count;
                  run_open_in = 1'b1;
               end
               awaited_in              = best_idx;
               pend_b_in.kind          = KIND_REFILL;
               pend_b_in.wanted_stream = STREAM_W'(best_idx);
            end
            state_in = has_a_in ? S_EMIT_A : S_EMIT_B;
         end
         S_EMIT_A: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = pend_a_ff;
               state_in   = S_EMIT_B;
            end
         end
         S_EMIT_B: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = pend_b_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         act_cfg_ff    <= ACTIVE_STREAMS_RST;
         klen_cfg_ff   <= KEY_LENGTH_RST;
         min_cnt_ff    <= MIN_COUNT_RST;
         head_valid_ff <= '0;
         ended_ff      <= '0;
         filling_ff    <= 1'b1;
         awaited_ff    <= '0;
         run_open_ff   <= 1'b0;
         cnt_ff        <= '0;
         look_vld_ff   <= 1'b0;
         has_a_ff      <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         act_cfg_ff    <= act_cfg_in;
         klen_cfg_ff   <= klen_cfg_in;
         min_cnt_ff    <= min_cnt_in;
         head_valid_ff <= head_valid_in;
         ended_ff      <= ended_in;
         filling_ff    <= filling_in;
         awaited_ff    <= awaited_in;
         run_open_ff   <= run_open_in;
         cnt_ff        <= cnt_in;
         look_vld_ff   <= look_vld_in;
         has_a_ff      <= has_a_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      item_stream_ff <= item_stream_in;
      item_key_ff    <= item_key_in;
      item_count_ff  <= item_count_in;
      item_eos_ff    <= item_eos_in;
      run_key_ff     <= run_key_in;
      run_sum_ff     <= run_sum_in;
      look_idx_ff    <= look_idx_in;
      pend_a_ff      <= pend_a_in;
      pend_b_ff      <= pend_b_in;
      rsp_ff         <= rsp_in;
   end

   // Result channel
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b00000, rsp_ff.wanted_stream, rsp_ff.total_count, rsp_ff.merged_key};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last_in_run;

endmodule

`default_nettype wire

@@ hw/rtl/kmsa_head_mem.sv @@
// Per-stream head entry store: key and count, one write and one registered read port.
// Depends on kmsa_pkg.
`default_nettype none

module kmsa_head_mem
   import kmsa_pkg::*;
#(
   parameter int NUM_STREAMS = NUM_STREAMS_DEF,
   parameter int KEY_W       = 8 * KEY_OCTETS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(NUM_STREAMS)-1:0] wr_addr,
   input  wire logic [KEY_W-1:0]               wr_key,
   input  wire logic [COUNT_W-1:0]             wr_count,
   input  wire logic [$clog2(NUM_STREAMS)-1:0] rd_addr,
   output logic      [KEY_W-1:0]               rd_key,
   output logic      [COUNT_W-1:0]             rd_count
);

   logic [KEY_W-1:0]   key_mem [NUM_STREAMS];
   logic [COUNT_W-1:0] cnt_mem [NUM_STREAMS];

   // Write a new head; the read port is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         cnt_mem[wr_addr] <= wr_count;
      end
      rd_key   <= key_mem[rd_addr];
      rd_count <= cnt_mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/kmsa_min_unit.sv @@
// Shared comparator that keeps the smallest head seen during one search sweep.
// Depends on kmsa_pkg.
`default_nettype none

module kmsa_min_unit
   import kmsa_pkg::*;
#(
   parameter int NUM_STREAMS = NUM_STREAMS_DEF,
   parameter int KEY_W       = 8 * KEY_OCTETS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire min_ctl_type                    ctl,
   input  wire logic                           cmp_live,
   input  wire logic [$clog2(NUM_STREAMS)-1:0] cmp_idx,
   input  wire logic [KEY_W-1:0]               cmp_key,
   input  wire logic [COUNT_W-1:0]             cmp_count,
   output logic                                best_found,
   output logic      [$clog2(NUM_STREAMS)-1:0] best_idx,
   output logic      [KEY_W-1:0]               best_key,
   output logic      [COUNT_W-1:0]             best_count
);

   localparam int IDX_W = $clog2(NUM_STREAMS);

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic              take;

   // Strictly smaller wins, so the lowest index keeps a tie
   assign take = ctl.compare && cmp_live && (!found_ff || (cmp_key < key_ff));

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         idx_in   = cmp_idx;
         key_in   = cmp_key;
         count_in = cmp_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff   <= idx_in;
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign best_found = found_ff;
   assign best_idx   = idx_ff;
   assign best_key   = key_ff;
   assign best_count = count_ff;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for kway_merge_sum_aggregate_top: directed table, then random
// merges under several register settings and idle profiles. Depends on kmsa_pkg and the RTL.
// Results are checked field by field against an in-bench merge predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kmsa_pkg::*;

   localparam int NSTREAMS          = NUM_STREAMS_DEF;
   localparam int SETTLE_CYCLES     = 24;
   localparam int STALL_LIMIT       = 2000;
   localparam int ITEMS_PER_SETTING = 135;
   localparam int DIRECTED_ROWS     = 22;

   // One input item, plus an optional expectation written into the table
   typedef struct packed {
      logic [STREAM_W-1:0]   stream;
      logic [KEY_FULL_W-1:0] key;
      logic [COUNT_W-1:0]    count;
      logic                  eos;
      logic                  typed;     // expectation given in the row
      logic                  answered;  // typed row causes one result
      kind_type              kind;
      logic [STREAM_W-1:0]   ws;
   } req_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [95:0]           req_tdata  = '0;
   logic [STREAM_W-1:0]   req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [103:0]          rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int send_gap_pct  = 35;
   int rsp_stall_pct = 56;
   int error_count   = 0;
   int items_sent    = 0;
   int merges_done   = 0;
   int idle_cycles   = 0;

   // Predictor state
   logic [KEY_FULL_W-1:0] hd_key [NSTREAMS];
   logic [COUNT_W-1:0]    hd_cnt [NSTREAMS];
   bit                    hd_full [NSTREAMS];
   bit                    src_done [NSTREAMS];
   logic [KEY_FULL_W-1:0] acc_key;
   logic [COUNT_W-1:0]    acc_sum;
   bit                    acc_open;
   logic [STREAM_W-1:0]   want_src;
   bit                    priming;
   logic [3:0]            cfg_active;
   logic [3:0]            cfg_keylen;
   logic [COUNT_W-1:0]    cfg_min;

   rsp_type               results_due [$];
   rsp_type               got_due;
   logic [KEY_FULL_W-1:0] planned_keys [NSTREAMS][$];

   req_item_type directed_rows [DIRECTED_ROWS] = '{
      // initial fill with extreme keys and counts; end marks carry junk key/count
      '{3'd0, 64'h0, 32'h0, 1'b0, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd0, 64'hDEAD, 32'd5, 1'b0, 1'b1, 1'b1, KIND_REJECT, 3'd0},
      '{3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd2, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd3, 64'd5, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd4, 64'd5, 32'd2, 1'b0, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd6, 64'h0, 32'h0, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd7, 64'h1234, 32'd9, 1'b1, 1'b1, 1'b1, KIND_REFILL, 3'd0},
      // wrong stream while stream 0 is awaited
      '{3'd3, 64'd9, 32'd1, 1'b0, 1'b1, 1'b1, KIND_REJECT, 3'd0},
      // equal heads pop lowest index first; zero sum below threshold is dropped
      '{3'd0, 64'h0, 32'h0, 1'b1, 1'b1, 1'b1, KIND_REFILL, 3'd3},
      // summing saturates
      '{3'd3, 64'h0, 32'h0, 1'b1, 1'b1, 1'b1, KIND_REFILL, 3'd4},
      '{3'd4, 64'h0, 32'h0, 1'b1, 1'b0, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd1, 64'h0, 32'h0, 1'b1, 1'b0, 1'b0, KIND_ENTRY, 3'd0},
      // empty merge: every stream ends at once
      '{3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd1, 64'h0, 32'h0, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd2, 64'h0, 32'h0, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd3, 64'h0, 32'h0, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd4, 64'h0, 32'h0, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd5, 64'h0, 32'h0, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd6, 64'h0, 32'h0, 1'b1, 1'b1, 1'b0, KIND_ENTRY, 3'd0},
      '{3'd7, 64'h0, 32'h0, 1'b1, 1'b1, 1'b1, KIND_DONE, 3'd0}
   };

   kway_merge_sum_aggregate_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned live_streams();
      int unsigned a;
      a = cfg_active;
      if (a < 1) a = 1;
      if (a > NSTREAMS) a = NSTREAMS;
      return a;
   endfunction

   function automatic logic [KEY_FULL_W-1:0] compare_mask();
      int unsigned kb;
      kb = cfg_keylen;
      if (kb < 1) kb = 1;
      if (kb > KEY_OCTETS_DEF) kb = KEY_OCTETS_DEF;
      if (kb >= 8) return '1;
      return ~64'd0 << (64 - 8 * kb);
   endfunction

   function automatic void push_result(kind_type kd, logic [KEY_FULL_W-1:0] k,
                                       logic [COUNT_W-1:0] c, logic [STREAM_W-1:0] ws,
                                       logic last);
      rsp_type r;
      r.kind          = kd;
      r.merged_key    = k;
      r.total_count   = c;
      r.wanted_stream = ws;
      r.last_in_run   = last;
      results_due = {results_due, r};
   endfunction

   function automatic void rearm_merge();
      for (int i = 0; i < NSTREAMS; i++) begin
         hd_key[i]   = '0;
         hd_cnt[i]   = '0;
         hd_full[i]  = 1'b0;
         src_done[i] = 1'b0;
      end
      acc_key  = '0;
      acc_sum  = '0;
      acc_open = 1'b0;
      want_src = '0;
      priming  = 1'b1;
      merges_done++;
   endfunction

   // Pop the smallest head into the running sum and ask for a refill, or finish the merge
   function automatic void pop_smallest();
      int unsigned           act;
      logic [KEY_FULL_W-1:0] mask;
      logic [KEY_FULL_W-1:0] k;
      logic [COUNT_W:0]      total;
      int                    best;
      act  = live_streams();
      mask = compare_mask();
      best = -1;
      for (int i = 0; i < act; i++) begin
         if (hd_full[i] && (best < 0 || (hd_key[i] & mask) < (hd_key[best] & mask)))
            best = i;
      end
      if (best < 0) begin
         if (acc_open && acc_sum >= cfg_min)
            push_result(KIND_ENTRY, acc_key, acc_sum, '0, 1'b0);
         push_result(KIND_DONE, '0, '0, '0, 1'b1);
         rearm_merge();
         return;
      end
      k             = hd_key[best] & mask;
      hd_full[best] = 1'b0;
      if (acc_open && acc_key == k) begin
         total   = {1'b0, acc_sum} + {1'b0, hd_cnt[best]};
         acc_sum = total[COUNT_W] ? '1 : total[COUNT_W-1:0];
      end else begin
         if (acc_open && acc_sum >= cfg_min)
            push_result(KIND_ENTRY, acc_key, acc_sum, '0, 1'b0);
         acc_key  = k;
         acc_sum  = hd_cnt[best];
         acc_open = 1'b1;
      end
      want_src = STREAM_W'(best);
      push_result(KIND_REFILL, '0, '0, STREAM_W'(best), 1'b1);
   endfunction

   // Apply one accepted item and queue the results it causes
   function automatic void merge_item(logic [STREAM_W-1:0] s, logic [KEY_FULL_W-1:0] k,
                                      logic [COUNT_W-1:0] c, logic e);
      int unsigned act;
      bit          ok;
      act = live_streams();
      ok  = (s < act) && !hd_full[s] && !src_done[s] && (priming || s == want_src);
      if (!ok) begin
         push_result(KIND_REJECT, '0, '0, '0, 1'b1);
         return;
      end
      if (e) begin
         src_done[s] = 1'b1;
      end else begin
         hd_key[s]  = k;
         hd_cnt[s]  = c;
         hd_full[s] = 1'b1;
      end
      if (priming) begin
         for (int i = 0; i < act; i++) begin
            if (!hd_full[i] && !src_done[i]) return;
         end
         priming = 1'b0;
      end
      pop_smallest();
   endfunction

   // ---------------------------------------------------------------- drivers

   // Idle at random, then hold the item until its transfer and predict its results
   task automatic send_item(input req_item_type item);
      int due_before;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {item.count, item.key};
      req_tuser  <= item.stream;
      req_tlast  <= item.eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due_before = results_due.size();
      merge_item(item.stream, item.key, item.count, item.eos);
      if (item.typed) begin
         while (results_due.size() > due_before) void'(results_due.pop_back());
         if (item.answered) push_result(item.kind, '0, '0, item.ws, 1'b1);
      end
      items_sent++;
   endtask

   // Write all registers once the block has drained and settled
   task automatic write_setting(input logic [3:0] act, input logic [3:0] klen,
                                input logic [COUNT_W-1:0] minc);
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_ACTIVE_STREAMS;
      csr_wdata <= {28'($urandom), act};
      @(posedge clock);
      csr_addr  <= CSR_KEY_LENGTH;
      csr_wdata <= {28'($urandom), klen};
      @(posedge clock);
      csr_addr  <= CSR_MIN_COUNT;
      csr_wdata <= minc;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_active = act;
      cfg_keylen = klen;
      cfg_min    = minc;
   endtask

   // One well-formed merge with random content, sprinkled with noise items
   task automatic run_merge();
      logic [KEY_FULL_W-1:0] key_pool [$];
      logic [KEY_FULL_W-1:0] k;
      int                    open_srcs [$];
      int                    pool_n;
      int                    idx;
      int                    start;
      int                    s;
      req_item_type          item;
      // Draw a small sorted key pool so that streams share keys
      pool_n = $urandom_range(1, 12);
      repeat (pool_n) begin
         k = {$urandom, $urandom};
         if ($urandom_range(0, 1)) begin
            k[63:56] = 8'($urandom_range(0, 2));
            k[55:48] = 8'($urandom_range(0, 2));
         end
         key_pool = {key_pool, k};
      end
      key_pool.sort();
      for (int i = 0; i < NSTREAMS; i++) begin
         planned_keys[i].delete();
         idx = $urandom_range(0, pool_n - 1);
         repeat ($urandom_range(0, 5)) begin
            planned_keys[i] = {planned_keys[i], key_pool[idx]};
            idx = idx + $urandom_range(0, 2);
            if (idx > pool_n - 1) idx = pool_n - 1;
         end
      end
      start = merges_done;
      while (merges_done == start) begin
         item = '0;
         if ($urandom_range(0, 99) < 6) begin
            item.stream = STREAM_W'($urandom_range(0, NSTREAMS - 1));
            item.key    = {$urandom, $urandom};
            item.count  = $urandom;
            item.eos    = 1'($urandom_range(0, 1));
         end else begin
            if (priming) begin
               open_srcs.delete();
               for (int i = 0; i < live_streams(); i++) begin
                  if (!hd_full[i] && !src_done[i]) open_srcs = {open_srcs, i};
               end
               s = open_srcs[$urandom_range(0, open_srcs.size() - 1)];
            end else begin
               s = want_src;
            end
            item.stream = STREAM_W'(s);
            case ($urandom_range(0, 9))
               0:       item.count = '1;
               1, 2:    item.count = $urandom;
               default: item.count = $urandom_range(0, 9);
            endcase
            if (planned_keys[s].size() == 0) begin
               item.eos = 1'b1;
               item.key = {$urandom, $urandom};
            end else begin
               item.key = planned_keys[s].pop_front();
            end
         end
         send_item(item);
      end
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, logic [KEY_FULL_W-1:0] want,
                                       logic [KEY_FULL_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Randomize the result stall, compare each result transfer, count quiet cycles
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            $error("result with nothing expected: kind %0d tdata 0x%0h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            got_due = results_due.pop_front();
            check_field("kind", 64'(got_due.kind), 64'(rsp_tuser));
            check_field("merged_key", got_due.merged_key, rsp_tdata[63:0]);
            check_field("total_count", 64'(got_due.total_count), 64'(rsp_tdata[95:64]));
            check_field("wanted_stream", 64'(got_due.wanted_stream), 64'(rsp_tdata[98:96]));
            check_field("pad", 64'd0, 64'(rsp_tdata[103:99]));
            check_field("last_in_run", 64'(got_due.last_in_run), 64'(rsp_tlast));
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [3:0]         act;
      logic [3:0]         klen;
      logic [COUNT_W-1:0] minc;
      int                 first_item;
      cfg_active = ACTIVE_STREAMS_RST;
      cfg_keylen = KEY_LENGTH_RST;
      cfg_min    = MIN_COUNT_RST;
      rearm_merge();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table under reset register values
      for (int r = 0; r < DIRECTED_ROWS; r++) send_item(directed_rows[r]);

      // Random merges: three idle profiles, four register settings each
      for (int p = 0; p < 3; p++) begin
         case (p)
            0:       begin send_gap_pct = 35; rsp_stall_pct = 56; end
            1:       begin send_gap_pct = 56; rsp_stall_pct = 35; end
            default: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         for (int g = 0; g < 4; g++) begin
            case (p * 4 + g)
               0: begin act = 4'd0;  klen = 4'd0;  minc = '0; end
               1: begin act = 4'd15; klen = 4'd15; minc = '1; end
               2: begin act = 4'd1;  klen = 4'd8;  minc = 32'd1; end
               3: begin act = 4'd8;  klen = 4'd1;  minc = 32'd2; end
               default: begin
                  act  = 4'($urandom_range(0, 15));
                  klen = 4'($urandom_range(0, 15));
                  case ($urandom_range(0, 4))
                     0:       minc = '0;
                     1:       minc = 32'd1;
                     2:       minc = $urandom_range(2, 20);
                     3:       minc = '1;
                     default: minc = $urandom;
                  endcase
               end
            endcase
            write_setting(act, klen, minc);
            first_item = items_sent;
            while (items_sent - first_item < ITEMS_PER_SETTING) run_merge();
         end
      end

      // Drain, then give stray results a chance to show up
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
